/* src/key_debounce_press_repeat_core_defines.svh */
// Assertion macros for the key debounce core.
`ifndef KEY_DEBOUNCE_PRESS_REPEAT_CORE_DEFINES_SVH
`define KEY_DEBOUNCE_PRESS_REPEAT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define KDPR_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define KDPR_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KDPR_ASSERT(label, clk, rstn, prop, msg)
`define KDPR_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

/* src/kdpr_pkg.sv */
`default_nettype none

package kdpr_pkg;

    localparam int KEY_COUNT = 8;
    localparam int DELAY_W   = 16;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_PRESS  = 2'd1;
    localparam logic [1:0] FUNC_REPEAT = 2'd2;

    localparam logic               CFG_REPEAT_DELAY = 1'b0;
    localparam logic               CFG_REPEAT_KEYS  = 1'b1;
    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 16'd150;
    localparam logic [KEY_COUNT-1:0] REPEAT_KEYS_RST = 8'd128;

    typedef struct packed {
        logic [1:0]           func;
        logic [KEY_COUNT-1:0] pins;
        logic [KEY_COUNT-1:0] read_mask;
    } item_t;

    typedef struct packed {
        logic [KEY_COUNT-1:0] key_state;
        logic [KEY_COUNT-1:0] taken;
    } result_t;

endpackage

`default_nettype wire

/* src/kdpr_keys.sv */
`default_nettype none

module kdpr_keys (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  fire,
    input  wire kdpr_pkg::item_t                       item,
    input  wire logic [kdpr_pkg::DELAY_W-1:0]          repeat_delay,
    input  wire logic [kdpr_pkg::KEY_COUNT-1:0]        repeat_keys,
    output kdpr_pkg::result_t                          result,
    output logic [kdpr_pkg::KEY_COUNT-1:0]             debounced
);

    localparam int K = kdpr_pkg::KEY_COUNT;
    localparam int D = kdpr_pkg::DELAY_W;

    logic [K-1:0] deb_reg, deb_next;
    logic [K-1:0] cl_reg, cl_next;
    logic [K-1:0] ch_reg, ch_next;
    logic [K-1:0] press_reg, press_next;
    logic [K-1:0] rep_reg, rep_next;
    logic [D-1:0] cnt_reg, cnt_next;

    logic [K-1:0] chg, tog, held, got;
    logic [D-1:0] cnt_base;

    always_comb begin
        deb_next   = deb_reg;
        cl_next    = cl_reg;
        ch_next    = ch_reg;
        press_next = press_reg;
        rep_next   = rep_reg;
        cnt_next   = cnt_reg;
        got        = '0;

        // vertical counter step
        chg      = deb_reg ^ ~item.pins;
        tog      = '0;
        held     = '0;
        cnt_base = cnt_reg;

        case (item.func)
            kdpr_pkg::FUNC_TICK: begin
                cl_next    = ~(cl_reg & chg);
                ch_next    = cl_next ^ (ch_reg & chg);
                tog        = chg & cl_next & ch_next;
                deb_next   = deb_reg ^ tog;
                press_next = press_reg | (deb_next & tog);
                held       = deb_next & repeat_keys;
                cnt_base   = (held == '0) ? repeat_delay : cnt_reg;
                cnt_next   = cnt_base - D'(1);
                if (cnt_next == '0) begin
                    rep_next = rep_reg | held;
                end
            end
            kdpr_pkg::FUNC_PRESS: begin
                got        = press_reg & item.read_mask;
                press_next = press_reg & ~got;
            end
            kdpr_pkg::FUNC_REPEAT: begin
                got      = rep_reg & item.read_mask;
                rep_next = rep_reg & ~got;
            end
            default: begin
                got = '0;
            end
        endcase

        result.key_state = deb_next;
        result.taken     = got;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg   <= '0;
            cl_reg    <= '0;
            ch_reg    <= '0;
            press_reg <= '0;
            rep_reg   <= '0;
            cnt_reg   <= '0;
        end else if (fire) begin
            deb_reg   <= deb_next;
            cl_reg    <= cl_next;
            ch_reg    <= ch_next;
            press_reg <= press_next;
            rep_reg   <= rep_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign debounced = deb_reg;

endmodule

`default_nettype wire

/* src/key_debounce_press_repeat_core.sv */
// Eight-key debouncer with press and repeat latches.
// Input channel (s_valid/s_ready): s_func 0 samples the active-low s_pins,
// 1 reads and clears the press latches selected by s_read_mask, 2 does the
// same for the repeat latches; code 3 changes nothing.
// Result channel (m_valid/m_ready): one word per input word, m_key_state is
// the debounced state after the word, m_taken the latched keys a read took
// (zero on a sample).
// Acceptance loads the input register; the word then moves into the result
// register once that is free, and m_valid is set with it.
// Throughput: one word per cycle while m_ready is high, set by the state
// update between the two registers, which is combinational.
// Configuration: cfg_wr_en with cfg_addr 0 writes the 16-bit repeat delay,
// cfg_addr 1 the repeat key mask; write only while no word is in flight.
// Reset (aresetn low, synchronous) empties both registers, clears all key
// state and latches, and loads delay 150 and repeat mask 0x80.
// When m_ready is low the result holds; one more word is taken into the
// input register, then s_ready drops until the result is taken.
`default_nettype none

`include "key_debounce_press_repeat_core_defines.svh"

module key_debounce_press_repeat_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic                                cfg_addr,
    input  wire logic [kdpr_pkg::DELAY_W-1:0]        cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_func,
    input  wire logic [kdpr_pkg::KEY_COUNT-1:0]      s_pins,
    input  wire logic [kdpr_pkg::KEY_COUNT-1:0]      s_read_mask,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [kdpr_pkg::KEY_COUNT-1:0]           m_key_state,
    output logic [kdpr_pkg::KEY_COUNT-1:0]           m_taken
);

    localparam int K = kdpr_pkg::KEY_COUNT;
    localparam int D = kdpr_pkg::DELAY_W;

    logic [D-1:0]      delay_reg;
    logic [K-1:0]      rkeys_reg;
    logic              in_valid_reg;
    kdpr_pkg::item_t   in_reg;
    logic              out_valid_reg;
    kdpr_pkg::result_t out_reg;

    logic              out_load;
    logic              fire;
    kdpr_pkg::result_t result;
    logic [K-1:0]      debounced;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= kdpr_pkg::REPEAT_DELAY_RST;
            rkeys_reg <= kdpr_pkg::REPEAT_KEYS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                kdpr_pkg::CFG_REPEAT_DELAY: delay_reg <= cfg_wdata;
                kdpr_pkg::CFG_REPEAT_KEYS:  rkeys_reg <= cfg_wdata[K-1:0];
                default: delay_reg <= delay_reg;
            endcase
        end
    end

    assign out_load = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_load;
    assign s_ready  = !in_valid_reg || out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.func      <= s_func;
            in_reg.pins      <= s_pins;
            in_reg.read_mask <= s_read_mask;
        end
    end

    kdpr_keys u_keys (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .item         (in_reg),
        .repeat_delay (delay_reg),
        .repeat_keys  (rkeys_reg),
        .result       (result),
        .debounced    (debounced)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_key_state = out_reg.key_state;
    assign m_taken     = out_reg.taken;

    `KDPR_ASSERT(a_tick_takes_nothing, aclk, aresetn,
        (fire && in_reg.func == kdpr_pkg::FUNC_TICK) |=> (m_taken == '0),
        "sample word returned latched keys")
    `KDPR_ASSERT(a_read_keeps_state, aclk, aresetn,
        (fire && in_reg.func != kdpr_pkg::FUNC_TICK) |=> (debounced == $past(debounced)),
        "debounced state changed on a read")
    `KDPR_ASSERT(a_result_matches_state, aclk, aresetn,
        fire |=> (m_key_state == debounced),
        "result key state differs from debounced state")
    `KDPR_ASSERT_RST(a_reset_empties, aclk,
        !aresetn |=> (!m_valid && !in_valid_reg),
        "pipeline not empty after reset")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_COUNT = kdpr_pkg::KEY_COUNT;
    localparam int DELAY_W = kdpr_pkg::DELAY_W;
    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES = 6;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_addr = 1'b0;
    logic [DELAY_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = '0;
    logic [KEY_COUNT-1:0] s_pins = '0;
    logic [KEY_COUNT-1:0] s_read_mask = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [KEY_COUNT-1:0] m_key_state;
    logic [KEY_COUNT-1:0] m_taken;

    // key words waiting to be sent, and the reports they should produce
    kdpr_pkg::item_t key_words[$];
    kdpr_pkg::result_t pending_reports[$];
    kdpr_pkg::item_t cur_word;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_cnt = 0;
    int quiet_cycles = 0;

    // shadow of the block's registers and key state
    logic [DELAY_W-1:0] delay_reg = kdpr_pkg::REPEAT_DELAY_RST;
    logic [KEY_COUNT-1:0] repeat_mask_reg = kdpr_pkg::REPEAT_KEYS_RST;
    logic [KEY_COUNT-1:0] db_state = '0;
    logic [KEY_COUNT-1:0] cnt_lo = '0;
    logic [KEY_COUNT-1:0] cnt_hi = '0;
    logic [KEY_COUNT-1:0] press_bits = '0;
    logic [KEY_COUNT-1:0] repeat_bits = '0;
    logic [DELAY_W-1:0] countdown = '0;

    key_debounce_press_repeat_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_pins(s_pins),
        .s_read_mask(s_read_mask),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_key_state(m_key_state),
        .m_taken(m_taken)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic kdpr_pkg::result_t apply_key_word(kdpr_pkg::item_t w);
        logic [KEY_COUNT-1:0] chg;
        logic [KEY_COUNT-1:0] held;
        logic [KEY_COUNT-1:0] got;
        kdpr_pkg::result_t r;
        got = '0;
        case (w.func)
            kdpr_pkg::FUNC_TICK: begin
                chg = db_state ^ ~w.pins;
                cnt_lo = ~(cnt_lo & chg);
                cnt_hi = cnt_lo ^ (cnt_hi & chg);
                chg = chg & cnt_lo & cnt_hi;
                db_state = db_state ^ chg;
                press_bits = press_bits | (db_state & chg);
                held = db_state & repeat_mask_reg;
                if (held == '0) begin
                    countdown = delay_reg;
                end
                countdown = countdown - DELAY_W'(1);
                if (countdown == '0) begin
                    repeat_bits = repeat_bits | held;
                end
            end
            kdpr_pkg::FUNC_PRESS: begin
                got = press_bits & w.read_mask;
                press_bits = press_bits & ~got;
            end
            kdpr_pkg::FUNC_REPEAT: begin
                got = repeat_bits & w.read_mask;
                repeat_bits = repeat_bits & ~got;
            end
            default: ;
        endcase
        r.key_state = db_state;
        r.taken = got;
        return r;
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pending_reports.push_back(apply_key_word(cur_word));
            end
            if (!s_valid || s_ready) begin
                if (key_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = key_words.pop_front();
                    s_valid <= 1'b1;
                    s_func <= cur_word.func;
                    s_pins <= cur_word.pins;
                    s_read_mask <= cur_word.read_mask;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        kdpr_pkg::result_t want;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected word: key_state=%h taken=%h", m_key_state, m_taken);
                end
            end else begin
                want = pending_reports.pop_front();
                if (m_key_state !== want.key_state || m_taken !== want.taken) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("word mismatch: key_state exp %h got %h, taken exp %h got %h",
                                 want.key_state, m_key_state, want.taken, m_taken);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void queue_word(logic [1:0] f, logic [KEY_COUNT-1:0] p,
                                       logic [KEY_COUNT-1:0] m);
        kdpr_pkg::item_t w;
        w.func = f;
        w.pins = p;
        w.read_mask = m;
        key_words.push_back(w);
    endfunction

    task automatic write_reg(input logic addr, input logic [DELAY_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == kdpr_pkg::CFG_REPEAT_DELAY) begin
            delay_reg = value;
        end else begin
            repeat_mask_reg = value[KEY_COUNT-1:0];
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (key_words.size() != 0 || s_valid || pending_reports.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // mostly press/release patterns held long enough to debounce, some bounce
    task automatic make_traffic(input int budget, input logic [DELAY_W-1:0] dly);
        int made;
        int len;
        int k;
        logic [KEY_COUNT-1:0] target;
        logic [KEY_COUNT-1:0] p;
        made = 0;
        target = '0;
        while (made < budget) begin
            k = $urandom_range(99);
            if (k < 55) begin
                if ($urandom_range(1)) begin
                    target = KEY_COUNT'($urandom);
                end else begin
                    target = target ^ (KEY_COUNT'(1) << $urandom_range(KEY_COUNT - 1));
                end
                k = $urandom_range(9);
                if (k < 2) begin
                    len = $urandom_range(1, 3);
                end else if (k == 9 && dly <= 160 && budget - made > dly) begin
                    len = dly + $urandom_range(1, 4);
                end else begin
                    len = $urandom_range(4, 9);
                end
                for (int i = 0; i < len; i++) begin
                    p = ~target;
                    if ($urandom_range(99) < 10) begin
                        p = p ^ (KEY_COUNT'(1) << $urandom_range(KEY_COUNT - 1));
                    end
                    queue_word(kdpr_pkg::FUNC_TICK, p, KEY_COUNT'($urandom));
                    made++;
                end
            end else if (k < 75) begin
                queue_word(kdpr_pkg::FUNC_PRESS, KEY_COUNT'($urandom),
                           ($urandom_range(3) == 0) ? {KEY_COUNT{1'b1}}
                                                    : KEY_COUNT'($urandom));
                made++;
            end else if (k < 93) begin
                queue_word(kdpr_pkg::FUNC_REPEAT, KEY_COUNT'($urandom),
                           ($urandom_range(3) == 0) ? {KEY_COUNT{1'b1}}
                                                    : KEY_COUNT'($urandom));
                made++;
            end else begin
                queue_word(FUNC_NOP, KEY_COUNT'($urandom), KEY_COUNT'($urandom));
                made++;
            end
        end
    endtask

    initial begin
        logic [DELAY_W-1:0] ph_delay[PHASES];
        logic [KEY_COUNT-1:0] ph_keys[PHASES];
        int ph_send[4];
        int ph_recv[4];
        logic [DELAY_W-1:0] kw;
        ph_delay = '{16'd150, 16'd1, 16'd0, 16'hFFFF, 16'd5, 16'd3};
        ph_keys = '{8'h80, 8'hFF, 8'h0F, 8'h00, 8'h00, 8'hFF};
        ph_send = '{0, 49, 0, 32};
        ph_recv = '{0, 0, 49, 32};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty reads, unused code, full press/release, counter restart
        queue_word(FUNC_NOP, 8'h00, 8'hFF);
        queue_word(kdpr_pkg::FUNC_PRESS, 8'hFF, 8'hFF);
        queue_word(kdpr_pkg::FUNC_REPEAT, 8'hFF, 8'hFF);
        repeat (4) queue_word(kdpr_pkg::FUNC_TICK, 8'h00, 8'h00);
        queue_word(kdpr_pkg::FUNC_PRESS, 8'h00, 8'h00);
        queue_word(kdpr_pkg::FUNC_PRESS, 8'h00, 8'h0F);
        queue_word(kdpr_pkg::FUNC_PRESS, 8'h00, 8'hFF);
        repeat (3) queue_word(kdpr_pkg::FUNC_TICK, 8'hFF, 8'hFF);
        queue_word(kdpr_pkg::FUNC_TICK, 8'h00, 8'hFF);
        repeat (4) queue_word(kdpr_pkg::FUNC_TICK, 8'hFF, 8'h00);
        queue_word(FUNC_NOP, 8'h55, 8'hAA);
        queue_word(kdpr_pkg::FUNC_REPEAT, 8'hAA, 8'h80);
        queue_word(kdpr_pkg::FUNC_PRESS, 8'h55, 8'hFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                if (ph == 4) begin
                    ph_delay[ph] = DELAY_W'($urandom_range(2, 12));
                    ph_keys[ph] = KEY_COUNT'($urandom);
                end
                write_reg(kdpr_pkg::CFG_REPEAT_DELAY, ph_delay[ph]);
                kw = DELAY_W'($urandom);
                kw[KEY_COUNT-1:0] = ph_keys[ph];
                write_reg(kdpr_pkg::CFG_REPEAT_KEYS, kw);
            end
            send_idle_pct = ph_send[ph % 4];
            recv_stall_pct = ph_recv[ph % 4];
            make_traffic(140, ph_delay[ph]);
        end

        wait_drained();
        repeat (6) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
